@@ rtl/core/rle_scanline_decoder_core_assert.svh @@
// assertion macros shared by the scanline decoder checkers
// expects clk and rst_n to be visible where a macro is used
`ifndef RLE_SCANLINE_DECODER_CORE_ASSERT_SVH
`define RLE_SCANLINE_DECODER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rsd_pkg.sv @@
// types and constants of the scanline run-length decoder
// no dependencies
`default_nettype none

package rsd_pkg;

  localparam int unsigned ValW   = 16;
  localparam int unsigned LenW   = 7;
  localparam int unsigned ColW   = 16;
  localparam int unsigned BytesW = 18;

  localparam logic [15:0] RowWidthReset = 16'd512;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ELEM  = 2'd1,
    OP_EOS   = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    CFG_ROW_WIDTH = 1'b0,
    CFG_WIDE      = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    KIND_RUN = 1'b0,
    KIND_ERR = 1'b1
  } kind_t;

  // what the front decided an accepted word is
  typedef enum logic [1:0] {
    CLS_START = 2'd0,
    CLS_ELEM  = 2'd1,
    CLS_EOS   = 2'd2,
    CLS_DROP  = 2'd3
  } cls_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_LITERAL = 4'b0100,
    PH_RUN     = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] element;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [ValW-1:0]   pixel_value;
    logic [LenW-1:0]   run_length;
    logic [ColW-1:0]   start_x;
    logic              row_end;
    logic [BytesW-1:0] bytes_used;
  } out_item_t;

  // queue entry between front and back
  typedef struct packed {
    cls_t            cls;
    logic [ValW-1:0] value;
    logic            wide;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/rsd_front.sv @@
// front end: decodes the op and masks the element by the element width
// depends on rsd_pkg
`default_nettype none

module rsd_front import rsd_pkg::*; (
  input  var in_item_t item,
  input  var logic     wide,
  output cmd_t         cmd,
  output logic         keep
);

  always_comb begin
    cmd.wide  = wide;
    cmd.value = wide ? item.element : {8'd0, item.element[7:0]};
    case (op_t'(item.op))
      OP_START: cmd.cls = CLS_START;
      OP_ELEM:  cmd.cls = CLS_ELEM;
      OP_EOS:   cmd.cls = CLS_EOS;
      default:  cmd.cls = CLS_DROP;
    endcase
    keep = (cmd.cls != CLS_DROP);
  end

endmodule

`default_nettype wire

@@ rtl/core/rsd_queue.sv @@
// two-entry command queue between front and back
// depends on rsd_pkg
`default_nettype none

module rsd_queue import rsd_pkg::*; (
  input  var logic clk,
  input  var logic rst_n,
  input  var logic push,
  input  var cmd_t push_cmd,
  output logic     full,
  input  var logic pop,
  output logic     not_empty,
  output cmd_t     head
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rsd_back.sv @@
// back end: row state machine, run delivery and output register
// depends on rsd_pkg
`default_nettype none

module rsd_back import rsd_pkg::*; #(
  parameter int unsigned MAX_ROW_WIDTH = 65535
) (
  input  var logic        clk,
  input  var logic        rst_n,
  input  var logic [15:0] row_width,
  input  var logic        cmd_valid,
  input  var cmd_t        cmd,
  output logic            cmd_pop,
  output logic            out_valid,
  input  var logic        out_stall,
  output out_item_t       out_item
);

  localparam logic [15:0] MaxW = 16'(MAX_ROW_WIDTH);

  phase_t            phase_r, phase_nxt;
  logic [15:0]       left_r, left_nxt;
  logic [LenW-1:0]   pkt_r, pkt_nxt;
  logic [ColW-1:0]   col_r, col_nxt;
  logic [BytesW-1:0] elems_r, elems_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r;

  logic              res_vld;
  out_item_t         res;
  logic              out_free;
  logic [15:0]       start_w;
  logic [LenW-1:0]   hdr_cnt;
  logic [LenW-1:0]   len;
  logic [15:0]       left_dec;
  logic [LenW-1:0]   pkt_dec;
  logic [BytesW-1:0] elems_inc;

  assign out_free = !out_valid_r || !out_stall;
  assign cmd_pop  = cmd_valid && (!res_vld || out_free);

  always_comb begin
    start_w = (row_width == 16'd0) ? 16'd1 : row_width;
    if (start_w > MaxW) begin
      start_w = MaxW;
    end
    hdr_cnt = cmd.value[LenW-1:0];
    if ({9'd0, hdr_cnt} > left_r) begin
      hdr_cnt = left_r[LenW-1:0];
    end
    len       = (phase_r == PH_LITERAL) ? 7'd1 : pkt_r;
    left_dec  = left_r - {9'd0, len};
    pkt_dec   = pkt_r - len;
    elems_inc = elems_r + 18'd1;
  end

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    pkt_nxt   = pkt_r;
    col_nxt   = col_r;
    elems_nxt = elems_r;
    res_vld   = 1'b0;
    res       = '0;
    res.start_x = col_r;
    case (cmd.cls)
      CLS_START: begin
        left_nxt  = start_w;
        pkt_nxt   = '0;
        col_nxt   = '0;
        elems_nxt = '0;
        phase_nxt = PH_HEADER;
      end
      CLS_EOS: begin
        if (phase_r != PH_IDLE) begin
          res_vld     = 1'b1;
          res.kind    = KIND_ERR;
          res.row_end = 1'b1;
          phase_nxt   = PH_IDLE;
        end
      end
      CLS_ELEM: begin
        if (phase_r != PH_IDLE) begin
          elems_nxt = elems_inc;
          if (phase_r == PH_HEADER) begin
            if (hdr_cnt == '0) begin
              // zero count while pixels remain aborts the row
              res_vld     = 1'b1;
              res.kind    = KIND_ERR;
              res.row_end = 1'b1;
              phase_nxt   = PH_IDLE;
            end else begin
              pkt_nxt   = hdr_cnt;
              phase_nxt = cmd.value[7] ? PH_LITERAL : PH_RUN;
            end
          end else begin
            res_vld         = 1'b1;
            res.kind        = KIND_RUN;
            res.pixel_value = cmd.value;
            res.run_length  = len;
            col_nxt         = col_r + {9'd0, len};
            left_nxt        = left_dec;
            pkt_nxt         = pkt_dec;
            if (left_dec == '0) begin
              res.row_end    = 1'b1;
              res.bytes_used = cmd.wide ? {elems_inc[BytesW-2:0], 1'b0} : elems_inc;
              phase_nxt      = PH_IDLE;
            end else if (pkt_dec == '0) begin
              phase_nxt = PH_HEADER;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = cmd_pop && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      left_r      <= '0;
      pkt_r       <= '0;
      col_r       <= '0;
      elems_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd_pop) begin
        phase_r <= phase_nxt;
        left_r  <= left_nxt;
        pkt_r   <= pkt_nxt;
        col_r   <= col_nxt;
        elems_r <= elems_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && res_vld) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

@@ rtl/core/rle_scanline_decoder_core.sv @@
// top level of the scanline run-length decoder
// depends on rsd_pkg, rsd_front, rsd_queue and rsd_back
`default_nettype none

// Decodes run-length packed scanlines, one code word per cycle while in_stall
// is low. A start word loads the row width, element words carry headers (bit
// 7 picks literal or run, low seven bits the count) and values, and every
// literal or run value gives one run word with its start column and length;
// the word that fills the row flags row_end and reports the compressed bytes.
// Sustained rate is one input word per cycle while in_stall is low. The front
// decodes each word into a two-entry queue; the back pops one entry per cycle
// unless a result waits on the stalled output register, and writes any result
// into the output register. in_stall rises only when the queue is full, which
// happens when out_stall holds the output register and a result is waiting to
// be written. Configuration writes land at once and are not synchronized to the
// queue: the front samples the element width and the back the row width, so
// write them only while no word is in flight.

module rle_scanline_decoder_core import rsd_pkg::*; #(
  parameter int unsigned MAX_ROW_WIDTH = 65535
) (
  input  var logic        clk,
  input  var logic        rst_n,
  // input channel
  input  var logic        in_valid,
  output logic            in_stall,
  input  var in_item_t    in_item,
  // result channel
  output logic            out_valid,
  input  var logic        out_stall,
  output out_item_t       out_item,
  // configuration
  input  var logic        cfg_we,
  input  var logic        cfg_idx,
  input  var logic [15:0] cfg_wdata
);

  logic [15:0] row_width_r;
  logic        wide_r;

  cmd_t front_cmd;
  logic front_keep;
  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  cmd_t q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= RowWidthReset;
      wide_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_ROW_WIDTH: row_width_r <= cfg_wdata;
        CFG_WIDE:      wide_r      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // front: classify and mask the element
  rsd_front u_front (
    .item (in_item),
    .wide (wide_r),
    .cmd  (front_cmd),
    .keep (front_keep)
  );

  // stall only on a full queue, never on the output side directly
  assign in_stall = q_full;
  // reserved ops are consumed here and never reach the back
  assign q_push   = in_valid && !q_full && front_keep;

  rsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: row state and output register
  rsd_back #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_width (row_width_r),
    .cmd_valid (q_not_empty),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

@@ rtl/core/rsd_checker.sv @@
// port-level checker for the scanline decoder, bound to the top level
// depends on rsd_pkg and rle_scanline_decoder_core_assert.svh
`default_nettype none

`include "rle_scanline_decoder_core_assert.svh"

module rsd_checker import rsd_pkg::*; (
  input var logic      clk,
  input var logic      rst_n,
  input var logic      out_valid,
  input var logic      out_stall,
  input var out_item_t out_item
);

  // a stalled result holds
  `RSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

  // an error always closes the row with empty value, length and byte fields
  `RSD_ASSERT_NOW(a_err_shape, out_valid && (out_item.kind == KIND_ERR), out_item.row_end && (out_item.run_length == '0) && (out_item.bytes_used == '0) && (out_item.pixel_value == '0), "malformed error result")

  // a delivered run always covers pixels
  `RSD_ASSERT_NOW(a_run_len, out_valid && (out_item.kind == KIND_RUN), out_item.run_length != '0, "empty run delivered")

  // byte count shows only on row end
  `RSD_ASSERT_NOW(a_bytes_end, out_valid && !out_item.row_end, out_item.bytes_used == '0, "byte count before row end")

endmodule

bind rle_scanline_decoder_core rsd_checker u_rsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
